@@ hw/rtl/mmbd_pkg.sv @@
package mmbd_pkg;

  // Field widths of the sample and point beats.
  localparam int TIME_W     = 48;
  localparam int VALUE_W    = 32;
  localparam int WIDTH_W    = 32;
  localparam int COUNT_W    = 15;
  localparam int SEQ_W      = 32;
  // Wide enough for the largest supported bucket index.
  localparam int BUCKET_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PASS_THROUGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET  = 3'd4;

  // Reset values of the registers that do not reset to zero.
  localparam logic [WIDTH_W-1:0] RST_BUCKET_WIDTH = 32'd1;
  localparam logic [COUNT_W-1:0] RST_BUCKET_COUNT = 15'd12500;

  typedef struct packed {
    logic [TIME_W-1:0]         sample_time;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      final_sample;
  } sample_t;

  typedef struct packed {
    logic [TIME_W-1:0]         point_time;
    logic signed [VALUE_W-1:0] point_value;
    logic                      run_end;
  } point_t;

  typedef struct packed {
    logic                pass_through;
    logic [TIME_W-1:0]   series_start;
    logic [WIDTH_W-1:0]  bucket_width;
    logic [COUNT_W-1:0]  bucket_count;
    logic [TIME_W-1:0]   time_offset;
  } cfg_t;

  // Classified sample handed from the front to the back.
  typedef struct packed {
    logic                      pass;
    logic                      fin;
    logic [BUCKET_W-1:0]       bucket;
    logic [TIME_W-1:0]         t;
    logic signed [VALUE_W-1:0] v;
  } cmd_t;

endpackage

@@ hw/rtl/min_max_bucket_decimator.sv @@
// Min/max bucket decimator: thins a time-ordered stream of samples for display.
// Samples arrive as beats on the input queue port (in_push, in_full, in_item).
// Points leave through the output queue port (out_empty, out_pop, out_item);
// the oldest point sits on out_item while out_empty is low. The plain write
// port cfg_we/cfg_index/cfg_data sets the registers and must only be used
// while the block is idle.
// A sample outside pass-through mode walks the front through DIFF, CHK, DIV
// and CLAMP to PUSH; DIV is skipped when the quotient is too large for an
// index and is clamped at once. The index comes from a restoring divider
// that yields one quotient bit per cycle, one step per index bit. A pass-through
// sample goes from IDLE straight to PUSH in the front.
// The back takes a sample that only updates the open bucket through EXEC
// and UPD; each flush adds SORT, MARK and one EMIT step per pick slot. A
// pass-through point is written from EXEC; on a bucket change the first
// point comes from EMIT, and a final sample passes through UPD first.
// A four-entry queue sits between front and back and an eight-entry queue
// holds finished points, so a stalled receiver only holds up the input once
// both queues are full. Reset empties both queues, forgets the open bucket
// and restores the register defaults; no clearing pass is needed.
module min_max_bucket_decimator #(
  parameter int MAX_BUCKETS = 16384
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  mmbd_pkg::sample_t                   in_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output mmbd_pkg::point_t                    out_item,
  input  logic                                cfg_we,
  input  logic [mmbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import mmbd_pkg::*;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  cfg_t   cfg_r;
  logic   cmd_wr;
  cmd_t   cmd_wdata;
  logic   cmd_full;
  logic   cmd_pop;
  cmd_t   cmd_rdata;
  logic   cmd_empty;
  logic   out_wr;
  point_t out_wdata;
  logic   out_full;

  // Register file: each write lands at the clock edge, unknown indexes are
  // dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pass_through <= 1'b0;
      cfg_r.series_start <= '0;
      cfg_r.bucket_width <= RST_BUCKET_WIDTH;
      cfg_r.bucket_count <= RST_BUCKET_COUNT;
      cfg_r.time_offset  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PASS_THROUGH: cfg_r.pass_through <= cfg_data[0];
        REG_SERIES_START: cfg_r.series_start <= cfg_data[TIME_W-1:0];
        REG_BUCKET_WIDTH: cfg_r.bucket_width <= cfg_data[WIDTH_W-1:0];
        REG_BUCKET_COUNT: cfg_r.bucket_count <= cfg_data[COUNT_W-1:0];
        REG_TIME_OFFSET:  cfg_r.time_offset  <= cfg_data[TIME_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Front: takes each beat and works out its bucket.
  mmbd_front #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_wr   (cmd_wr),
    .cmd_data (cmd_wdata),
    .cmd_full (cmd_full)
  );

  mmbd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_wdata),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rdata),
    .empty   (cmd_empty)
  );

  // Back: keeps the picks of the open bucket and flushes them as points.
  mmbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_rdata),
    .out_full  (out_full),
    .out_wr    (out_wr),
    .out_data  (out_wdata)
  );

  mmbd_fifo #(
    .WIDTH($bits(point_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_wr),
    .wr_data (out_wdata),
    .full    (out_full),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

@@ hw/rtl/mmbd_fifo.sv @@
module mmbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/mmbd_front.sv @@
module mmbd_front #(
  parameter int MAX_BUCKETS = 16384
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mmbd_pkg::cfg_t    cfg,
  input  logic             in_push,
  output logic             in_full,
  input  mmbd_pkg::sample_t in_item,
  output logic             cmd_wr,
  output mmbd_pkg::cmd_t    cmd_data,
  input  logic             cmd_full
);

  import mmbd_pkg::*;

  localparam int QB     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int STEP_W = (QB > 1) ? $clog2(QB) : 1;
  localparam int DW     = (TIME_W > WIDTH_W + QB) ? TIME_W : WIDTH_W + QB;

  typedef enum logic [2:0] {
    F_IDLE, F_DIFF, F_CHK, F_DIV, F_CLAMP, F_PUSH
  } fstate_t;

  fstate_t            state_r;
  sample_t            item_r;
  logic               pass_r;
  logic [TIME_W-1:0]  diff_r;
  logic [WIDTH_W-1:0] w_r;
  logic [WIDTH_W-1:0] rem_r;
  logic [QB-1:0]      low_r;
  logic [QB-1:0]      q_r;
  logic [STEP_W-1:0]  step_r;
  logic [QB-1:0]      idx_r;

  logic [TIME_W:0]    sub;
  logic               ovf;
  logic [WIDTH_W:0]   trial;
  logic               fits;
  logic [WIDTH_W-1:0] rem_new;
  logic [31:0]        cnt_c;
  logic [31:0]        lim32;
  logic [QB-1:0]      lim;

  assign sub     = {1'b0, item_r.sample_time} - {1'b0, cfg.series_start};
  assign ovf     = DW'(diff_r) >= DW'({w_r, {QB{1'b0}}});
  assign trial   = {rem_r, low_r[QB-1]};
  assign fits    = trial >= {1'b0, w_r};
  assign rem_new = WIDTH_W'(trial - {1'b0, w_r});

  // Effective bucket count: zero counts as one, capped at capacity.
  always_comb begin
    cnt_c = 32'(cfg.bucket_count);
    if (cnt_c == '0) begin
      cnt_c = 32'd1;
    end
    if (cnt_c > 32'(MAX_BUCKETS)) begin
      cnt_c = 32'(MAX_BUCKETS);
    end
    lim32 = cnt_c - 32'd1;
    lim   = lim32[QB-1:0];
  end

  assign in_full         = (state_r != F_IDLE);
  assign cmd_wr          = (state_r == F_PUSH) && !cmd_full;
  assign cmd_data.pass   = pass_r;
  assign cmd_data.fin    = item_r.final_sample;
  assign cmd_data.bucket = BUCKET_W'(idx_r);
  assign cmd_data.t      = item_r.sample_time;
  assign cmd_data.v      = item_r.sample_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_push) begin
            item_r <= in_item;
            pass_r <= cfg.pass_through;
            idx_r  <= '0;
            state_r <= cfg.pass_through ? F_PUSH : F_DIFF;
          end
        end
        F_DIFF: begin
          // A sample before the series start lands in bucket zero.
          diff_r  <= sub[TIME_W] ? '0 : sub[TIME_W-1:0];
          w_r     <= (cfg.bucket_width == '0) ? WIDTH_W'(1) : cfg.bucket_width;
          state_r <= F_CHK;
        end
        F_CHK: begin
          if (ovf) begin
            q_r     <= '1;
            state_r <= F_CLAMP;
          end else begin
            rem_r   <= WIDTH_W'(diff_r >> QB);
            low_r   <= diff_r[QB-1:0];
            step_r  <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r <= fits ? rem_new : trial[WIDTH_W-1:0];
          q_r   <= QB'({q_r, fits});
          low_r <= QB'({low_r, 1'b0});
          if (step_r == STEP_W'(QB - 1)) begin
            state_r <= F_CLAMP;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        F_CLAMP: begin
          idx_r   <= (q_r > lim) ? lim : q_r;
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!cmd_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/mmbd_back.sv @@
module mmbd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mmbd_pkg::cfg_t  cfg,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  mmbd_pkg::cmd_t  cmd_data,
  input  logic           out_full,
  output logic           out_wr,
  output mmbd_pkg::point_t out_data
);

  import mmbd_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0]         t;
    logic signed [VALUE_W-1:0] v;
    logic [SEQ_W-1:0]          seq;
  } pick_t;

  typedef enum logic [2:0] {
    B_IDLE, B_EXEC, B_SORT, B_MARK, B_EMIT, B_UPD
  } bstate_t;

  // Pick slots: first, minimum, maximum, latest.
  localparam int P_FIRST  = 0;
  localparam int P_LOW    = 1;
  localparam int P_HIGH   = 2;
  localparam int P_LATEST = 3;

  bstate_t             state_r;
  cmd_t                cur_r;
  pick_t               pick_r [4];
  pick_t               srt_r [4];
  logic [3:0]          keep_r;
  logic [1:0]          lastk_r;
  logic [1:0]          pos_r;
  logic                used_r;
  logic [BUCKET_W-1:0] open_r;
  logic [SEQ_W-1:0]    seq_r;
  logic                end_flush_r;
  logic                fin_flush_r;

  logic [SEQ_W-1:0]    rel [4];
  logic [1:0]          rank [4];
  pick_t               srt_nxt [4];
  logic [3:0]          keep_nxt;
  logic [1:0]          lastk_nxt;
  pick_t               s_new;
  logic                emit_go;
  pick_t               emit_p;

  function automatic point_t make_point(input logic [TIME_W-1:0] t,
                                        input logic signed [VALUE_W-1:0] v,
                                        input logic re,
                                        input logic [TIME_W-1:0] off);
    point_t p;
    p.point_time  = (t > off) ? t - off : '0;
    p.point_value = v;
    p.run_end     = re;
    return p;
  endfunction

  // Stable sort of the four picks by arrival order relative to the first.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rel[i] = pick_r[i].seq - pick_r[P_FIRST].seq;
    end
    for (int i = 0; i < 4; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (j != i) begin
          if (rel[j] < rel[i] || (rel[j] == rel[i] && j < i)) begin
            rank[i] = rank[i] + 2'd1;
          end
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      srt_nxt[k] = pick_r[P_FIRST];
      for (int i = 0; i < 4; i++) begin
        if (rank[i] == 2'(k)) begin
          srt_nxt[k] = pick_r[i];
        end
      end
    end
  end

  // Repeated picks sit next to each other once sorted.
  always_comb begin
    keep_nxt[0] = 1'b1;
    for (int k = 1; k < 4; k++) begin
      keep_nxt[k] = (srt_r[k].seq != srt_r[k-1].seq);
    end
    lastk_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      if (keep_nxt[k]) begin
        lastk_nxt = 2'(k);
      end
    end
  end

  assign s_new.t   = cur_r.t;
  assign s_new.v   = cur_r.v;
  assign s_new.seq = seq_r;

  assign emit_p  = srt_r[pos_r];
  assign emit_go = !keep_r[pos_r] || !out_full;
  assign cmd_pop = (state_r == B_IDLE) && !cmd_empty;

  always_comb begin
    out_wr   = 1'b0;
    out_data = make_point(cur_r.t, cur_r.v, 1'b1, cfg.time_offset);
    case (state_r)
      B_EXEC: begin
        out_wr = cur_r.pass && !out_full;
      end
      B_EMIT: begin
        out_wr   = keep_r[pos_r] && !out_full;
        out_data = make_point(emit_p.t, emit_p.v,
                              end_flush_r && (pos_r == lastk_r), cfg.time_offset);
      end
      default: begin
        out_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      used_r  <= 1'b0;
      open_r  <= '0;
      seq_r   <= '0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!cmd_empty) begin
            cur_r   <= cmd_data;
            state_r <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (cur_r.pass) begin
            if (!out_full) begin
              state_r <= B_IDLE;
            end
          end else if (used_r && cur_r.bucket != open_r) begin
            // Bucket change: the close is the last flush unless a final follows.
            end_flush_r <= !cur_r.fin;
            fin_flush_r <= 1'b0;
            state_r     <= B_SORT;
          end else begin
            state_r <= B_UPD;
          end
        end
        B_SORT: begin
          for (int k = 0; k < 4; k++) begin
            srt_r[k] <= srt_nxt[k];
          end
          state_r <= B_MARK;
        end
        B_MARK: begin
          keep_r  <= keep_nxt;
          lastk_r <= lastk_nxt;
          pos_r   <= '0;
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (emit_go) begin
            if (pos_r == 2'd3) begin
              used_r <= 1'b0;
              if (fin_flush_r) begin
                open_r  <= '0;
                seq_r   <= '0;
                state_r <= B_IDLE;
              end else begin
                state_r <= B_UPD;
              end
            end else begin
              pos_r <= pos_r + 2'd1;
            end
          end
        end
        B_UPD: begin
          seq_r <= seq_r + 1'b1;
          if (used_r) begin
            if (cur_r.v < pick_r[P_LOW].v) begin
              pick_r[P_LOW] <= s_new;
            end
            if (cur_r.v > pick_r[P_HIGH].v) begin
              pick_r[P_HIGH] <= s_new;
            end
            pick_r[P_LATEST] <= s_new;
          end else begin
            for (int i = 0; i < 4; i++) begin
              pick_r[i] <= s_new;
            end
            open_r <= cur_r.bucket;
            used_r <= 1'b1;
          end
          if (cur_r.fin) begin
            end_flush_r <= 1'b1;
            fin_flush_r <= 1'b1;
            state_r     <= B_SORT;
          end else begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/mmbd_checker.sv @@
module mmbd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input mmbd_pkg::point_t  out_item
);

  import mmbd_pkg::*;

  // Reset leaves the block ready for a beat with no point waiting.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("block not idle after reset");

  // The front holds one sample at a time, so an accepted beat blocks the next.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("input ready in the cycle after a beat was taken");

  // A waiting point stays put until it is popped.
  a_point_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting point changed or vanished");

endmodule

bind min_max_bucket_decimator mmbd_checker u_chk (.*);

@@ bench/tb_min_max_bucket_decimator.sv @@
module tb_min_max_bucket_decimator;
  import mmbd_pkg::*;

  // Bucket capacity of the instance below (the block's default size).
  localparam int MAX_BKT = 16384;
  // Cycles allowed for samples that cause no point to drain out of the block:
  // the divider front, the four-entry command queue and the back's update.
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_ITEMS  = 180;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_HOLD, POP_SPARSE} pop_mode_t;

  // One kept sample of the open bucket: time, value and arrival number.
  typedef struct packed {
    logic [TIME_W-1:0]         t;
    logic signed [VALUE_W-1:0] v;
    logic [SEQ_W-1:0]          seq;
  } pick_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  sample_t               in_item   = '0;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  point_t                out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Register copies held by the predictor; they follow every write.
  logic                set_pass   = 1'b0;
  logic [TIME_W-1:0]   set_start  = '0;
  logic [WIDTH_W-1:0]  set_width  = RST_BUCKET_WIDTH;
  logic [COUNT_W-1:0]  set_count  = RST_BUCKET_COUNT;
  logic [TIME_W-1:0]   set_offset = '0;

  // Predicted state of the open bucket.
  logic                bucket_live = 1'b0;
  logic [31:0]         live_bucket = '0;
  logic [SEQ_W-1:0]    next_seq    = '0;
  pick_t               pick_first, pick_low, pick_high, pick_last;

  // Points expected from the block, oldest first, and the points of the
  // sample currently being predicted.
  point_t              pending_points[$];
  point_t              step_points[$];
  point_t              expected_point;

  int                  fail_count   = 0;
  int                  cycle_count  = 0;
  int                  random_items = 0;
  int                  burst_left   = 0;
  int                  pop_left     = 0;
  pop_mode_t           pop_mode     = POP_ALWAYS;
  // Largest step between sample times, forward or back, in the current random phase.
  logic [31:0]         step_span    = 32'd2;

  min_max_bucket_decimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The run is abandoned if it goes on far longer than the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A point carries the sample time shifted down by the offset, clamped at
  // zero so that an offset beyond the time never wraps round.
  function automatic point_t make_point(input logic [TIME_W-1:0] t,
                                        input logic signed [VALUE_W-1:0] v);
    point_t p;
    p.point_time  = (t > set_offset) ? t - set_offset : '0;
    p.point_value = v;
    p.run_end     = 1'b0;
    return p;
  endfunction

  // Emits the kept picks of the open bucket in arrival order. A sample that
  // is, say, both the first and the minimum is emitted once only. Arrival
  // order is measured from the bucket's first sample so that a wrapped
  // sequence number still sorts correctly.
  function automatic void close_bucket();
    pick_t            order [4];
    pick_t            x;
    int               i;
    int               j;
    logic [SEQ_W-1:0] prev;
    logic [SEQ_W-1:0] rel_x;
    logic [SEQ_W-1:0] rel_j;
    bit               have;
    if (!bucket_live)
      return;
    order[0] = pick_first;
    order[1] = pick_low;
    order[2] = pick_high;
    order[3] = pick_last;
    for (i = 1; i < 4; i++) begin
      x     = order[i];
      rel_x = x.seq - pick_first.seq;
      j     = i - 1;
      while (j >= 0) begin
        rel_j = order[j].seq - pick_first.seq;
        if (rel_j <= rel_x)
          break;
        order[j+1] = order[j];
        j--;
      end
      order[j+1] = x;
    end
    have = 1'b0;
    prev = '0;
    for (i = 0; i < 4; i++) begin
      if (!have || order[i].seq != prev) begin
        have = 1'b1;
        prev = order[i].seq;
        step_points.insert(step_points.size(), make_point(order[i].t, order[i].v));
      end
    end
    bucket_live = 1'b0;
  endfunction

  // Works out the points that one accepted sample causes and queues them.
  function automatic void predict_points(input sample_t s);
    logic [TIME_W-1:0]         t;
    logic signed [VALUE_W-1:0] val;
    logic [63:0]               w;
    logic [63:0]               cnt;
    logic [63:0]               idx;
    pick_t                     cur;
    point_t                    last;
    t   = s.sample_time;
    val = s.sample_value;
    step_points.delete();
    if (set_pass) begin
      // Pass-through leaves the bucket state and the sequence untouched,
      // even for a final sample.
      step_points.insert(step_points.size(), make_point(t, val));
    end else begin
      // A zero width or count behaves as one; the count is capped at the
      // block's capacity.
      w   = (set_width == '0) ? 64'd1 : 64'(set_width);
      cnt = (set_count == '0) ? 64'd1 : 64'(set_count);
      if (cnt > 64'(MAX_BKT))
        cnt = 64'(MAX_BKT);
      // Samples before the start of the series land in bucket zero, and the
      // last bucket takes everything beyond the end.
      if (t > set_start)
        idx = 64'(t - set_start) / w;
      else
        idx = '0;
      if (idx > cnt - 1)
        idx = cnt - 1;
      cur.t    = t;
      cur.v    = val;
      cur.seq  = next_seq;
      next_seq = next_seq + 1'b1;
      // Any change of bucket closes the open one, backwards as well.
      if (bucket_live && idx[31:0] != live_bucket)
        close_bucket();
      if (!bucket_live) begin
        pick_first  = cur;
        pick_low    = cur;
        pick_high   = cur;
        pick_last   = cur;
        live_bucket = idx[31:0];
        bucket_live = 1'b1;
      end else begin
        // Strict comparisons: on a tie the earlier sample is kept.
        if (val < pick_low.v)
          pick_low = cur;
        if (val > pick_high.v)
          pick_high = cur;
        pick_last = cur;
      end
      if (s.final_sample) begin
        close_bucket();
        live_bucket = '0;
        next_seq    = '0;
      end
    end
    if (step_points.size() != 0) begin
      last         = step_points.pop_back();
      last.run_end = 1'b1;
      step_points.insert(step_points.size(), last);
    end
    while (step_points.size() != 0)
      pending_points.insert(pending_points.size(), step_points.pop_front());
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls in phases of its own, and every point
  // beat taken is checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_points.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected point: time %0h value %0d end %0b",
                   out_item.point_time, out_item.point_value, out_item.run_end);
      end else begin
        expected_point = pending_points.pop_front();
        if (out_item.point_time !== expected_point.point_time ||
            out_item.point_value !== expected_point.point_value ||
            out_item.run_end !== expected_point.run_end) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: time exp %0h got %0h, value exp %0d got %0d, end exp %0b got %0b",
                     expected_point.point_time, out_item.point_time,
                     expected_point.point_value, out_item.point_value,
                     expected_point.run_end, out_item.run_end);
        end
      end
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      // The stall pattern is redrawn whenever a phase runs out: taking every beat,
      // tossing a coin, holding off completely, or taking one beat in four.
      if (pop_left == 0) begin
        pop_mode = pop_mode_t'($urandom_range(0, 3));
        pop_left = $urandom_range(4, 48);
      end
      pop_left--;
      case (pop_mode)
        POP_ALWAYS: out_pop <= 1'b1;
        POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
        POP_HOLD:   out_pop <= 1'b0;
        default:    out_pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------

  function automatic sample_t sample_of(input logic [TIME_W-1:0] t,
                                        input logic signed [VALUE_W-1:0] v,
                                        input logic fin);
    sample_t s;
    s.sample_time  = t;
    s.sample_value = v;
    s.final_sample = fin;
    return s;
  endfunction

  // Offers one sample beat and returns at the edge that accepts it. Beats go
  // out in bursts of random length; between bursts push drops for a random
  // gap, and some bursts follow on with no gap at all.
  task automatic push_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_push <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (in_full)
      @(posedge clk);
    predict_points(s);
  endtask

  // Holds the sender back until every expected point has arrived, then lets
  // any sample that causes no point work its way through the block.
  task automatic settle_block();
    in_push <= 1'b0;
    while (pending_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are only issued while the block is settled.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_PASS_THROUGH: set_pass   = data[0];
      REG_SERIES_START: set_start  = data[TIME_W-1:0];
      REG_BUCKET_WIDTH: set_width  = data[WIDTH_W-1:0];
      REG_BUCKET_COUNT: set_count  = data[COUNT_W-1:0];
      REG_TIME_OFFSET:  set_offset = data[TIME_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly full-range values, with a share of tiny values so that ties on
  // the minimum and maximum are common, and the two extremes.
  function automatic logic signed [VALUE_W-1:0] draw_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5)
      return $urandom;
    else if (k < 8)
      return $signed(32'($urandom_range(0, 6))) - 32'sd3;
    else if (k == 8)
      return 32'sh7FFF_FFFF;
    else
      return 32'sh8000_0000;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: each time unit is a bucket of its own.
  task automatic test_default_buckets();
    // Extremes of the value in one bucket; the repeated maximum must not
    // displace the first one.
    push_sample(sample_of(48'd0, 32'sh7FFF_FFFF, 1'b0));
    push_sample(sample_of(48'd0, 32'sh8000_0000, 1'b0));
    push_sample(sample_of(48'd0, 32'sh7FFF_FFFF, 1'b0));
    // The next bucket closes the first; the final sample flushes its own.
    push_sample(sample_of(48'd1, 32'sd5, 1'b0));
    push_sample(sample_of(48'd1, 32'sd5, 1'b1));
    // Four distinct picks, then a final sample in a new bucket: five points
    // from one beat.
    push_sample(sample_of(48'd2, 32'sd0, 1'b0));
    push_sample(sample_of(48'd2, -32'sd5, 1'b0));
    push_sample(sample_of(48'd2, 32'sd9, 1'b0));
    push_sample(sample_of(48'd2, 32'sd3, 1'b0));
    push_sample(sample_of(48'd3, 32'sd7, 1'b1));
  endtask

  task automatic test_pass_through();
    settle_block();
    write_reg(REG_PASS_THROUGH, 48'd1);
    write_reg(REG_TIME_OFFSET, '1);
    push_sample(sample_of('1, -32'sd1, 1'b0));
    settle_block();
    write_reg(REG_TIME_OFFSET, 48'h100);
    // An offset beyond the time clamps the point time to zero.
    push_sample(sample_of(48'hFF, 32'sh1234_5678, 1'b1));
    push_sample(sample_of('1, 32'sd0, 1'b0));
    // A final sample in pass-through must leave an open bucket alone.
    settle_block();
    write_reg(REG_PASS_THROUGH, 48'd0);
    write_reg(REG_TIME_OFFSET, 48'd0);
    push_sample(sample_of(48'd10, 32'sd1, 1'b0));
    settle_block();
    write_reg(REG_PASS_THROUGH, 48'd1);
    push_sample(sample_of(48'd20, 32'sd2, 1'b1));
    settle_block();
    write_reg(REG_PASS_THROUGH, 48'd0);
    push_sample(sample_of(48'd10, 32'sd3, 1'b1));
  endtask

  task automatic test_degenerate_settings();
    // A zero width counts as one; a time before the start goes to bucket
    // zero, which also takes the index backwards.
    settle_block();
    write_reg(REG_BUCKET_WIDTH, 48'd0);
    write_reg(REG_BUCKET_COUNT, 48'd4);
    write_reg(REG_SERIES_START, 48'd100);
    push_sample(sample_of(48'd100, 32'sd1, 1'b0));
    push_sample(sample_of(48'd101, 32'sd2, 1'b0));
    push_sample(sample_of(48'd50, 32'sd3, 1'b0));
    // A zero count leaves a single bucket for every time.
    settle_block();
    write_reg(REG_BUCKET_COUNT, 48'd0);
    push_sample(sample_of('1, 32'sd4, 1'b1));
    // A count above capacity is capped, so far-off times share the last
    // bucket; a step back closes it.
    settle_block();
    write_reg(REG_BUCKET_COUNT, 48'h7FFF);
    write_reg(REG_BUCKET_WIDTH, 48'd1);
    write_reg(REG_SERIES_START, 48'd0);
    push_sample(sample_of(48'h3FFF_0000_0000, -32'sd7, 1'b0));
    push_sample(sample_of(48'd16383, 32'sd8, 1'b0));
    push_sample(sample_of(48'd16382, -32'sd9, 1'b1));
    // Widest bucket and latest start.
    settle_block();
    write_reg(REG_BUCKET_WIDTH, 48'hFFFF_FFFF);
    write_reg(REG_SERIES_START, '1);
    write_reg(REG_BUCKET_COUNT, 48'd3);
    push_sample(sample_of('1, 32'sh1234, 1'b1));
  endtask

  // Picks a fresh setting for every register, the extremes among them.
  task automatic configure_random_setting();
    logic [TIME_W-1:0]  new_start;
    logic [TIME_W-1:0]  new_offset;
    logic [WIDTH_W-1:0] new_width;
    logic [COUNT_W-1:0] new_count;
    settle_block();
    case ($urandom_range(0, 4))
      0:       new_start = '0;
      1:       new_start = '1;
      default: new_start = 48'({$urandom_range(0, 255), $urandom});
    endcase
    case ($urandom_range(0, 5))
      0:       new_width = '0;
      1:       new_width = '1;
      default: new_width = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 7))
      0:       new_count = '0;
      1:       new_count = 15'(MAX_BKT);
      2:       new_count = 15'($urandom_range(MAX_BKT + 1, 32767));
      3:       new_count = RST_BUCKET_COUNT;
      default: new_count = 15'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 4))
      0:       new_offset = '0;
      1:       new_offset = '1;
      2:       new_offset = 48'({$urandom, $urandom});
      default: new_offset = (new_start > 48'd50) ? new_start - $urandom_range(0, 50) : '0;
    endcase
    // Steps of up to about two buckets close buckets often without
    // skipping most of them.
    if (new_width == '0)
      step_span = 32'd2;
    else if (new_width == '1)
      step_span = '1;
    else
      step_span = 32'(new_width) * 2;
    write_reg(REG_PASS_THROUGH, 48'($urandom_range(0, 5) == 0));
    write_reg(REG_SERIES_START, new_start);
    write_reg(REG_BUCKET_WIDTH, 48'(new_width));
    write_reg(REG_BUCKET_COUNT, 48'(new_count));
    write_reg(REG_TIME_OFFSET, new_offset);
  endtask

  // One series: times mostly climbing from the start of the series, with an
  // occasional jump anywhere or step back, and usually a final sample at the
  // end.
  task automatic run_series(input int n);
    logic [TIME_W-1:0] t;
    logic              fin;
    int                i;
    int                kind;
    if ($urandom_range(0, 7) == 0)
      t = 48'({$urandom, $urandom});
    else
      t = (set_start > 48'd8) ? set_start - $urandom_range(0, 8) : set_start;
    for (i = 0; i < n; i++) begin
      kind = $urandom_range(0, 19);
      if (kind == 0)
        t = 48'({$urandom, $urandom});
      else if (kind == 1)
        t = t - $urandom_range(0, step_span);
      else
        t = t + $urandom_range(0, step_span);
      if (i == n - 1)
        fin = ($urandom_range(0, 3) != 0);
      else
        fin = ($urandom_range(0, 40) == 0);
      push_sample(sample_of(t, draw_value(), fin));
      random_items++;
    end
  endtask

  task automatic test_random_series();
    while (random_items < RANDOM_ITEMS) begin
      configure_random_setting();
      run_series($urandom_range(4, 30));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_buckets();
    test_pass_through();
    test_degenerate_settings();
    test_random_series();
    // Every expected point must arrive, and nothing more may follow.
    settle_block();
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mmbd_pkg.sv
hw/rtl/mmbd_fifo.sv
hw/rtl/mmbd_front.sv
hw/rtl/mmbd_back.sv
hw/rtl/min_max_bucket_decimator.sv
hw/rtl/mmbd_checker.sv
bench/tb_min_max_bucket_decimator.sv
